// File: design/dmsfr_pkg.sv
// Package for the dual mode serial frame receiver.
// Holds buffer sizes, frame codes, sequencer states and the binary decode struct.
// No dependencies.
package dmsfr_pkg;

  // buffer sizes
  localparam int TEXT_BUF_DEPTH = 32;
  localparam int BIN_FRAME_MAX  = 64;
  localparam int TEXT_PTR_W     = $clog2(TEXT_BUF_DEPTH);
  localparam int BIN_ADDR_W     = $clog2(BIN_FRAME_MAX);

  // field widths
  localparam int BYTE_W      = 8;
  localparam int FRAME_LEN_W = 7;
  localparam int BIN_IDX_W   = 7;
  localparam int SUM_W       = 16;
  localparam int SIZE_W      = 17;

  // markers and header bytes
  localparam logic [BYTE_W-1:0] OPEN_MARK  = 8'h28;
  localparam logic [BYTE_W-1:0] CLOSE_MARK = 8'h29;
  localparam logic [BYTE_W-1:0] PRE0       = 8'hBB;
  localparam logic [BYTE_W-1:0] PRE1       = 8'h00;
  localparam logic [SIZE_W-1:0] SIZE_EXTRA = 17'd10;

  // header positions (index after the byte is stored)
  localparam logic [BIN_IDX_W-1:0] IDX_PREAMBLE_DONE = 7'd2;
  localparam logic [BIN_IDX_W-1:0] IDX_LENGTH_DONE   = 7'd8;
  localparam logic [BIN_IDX_W-1:0] IDX_MIN_END       = 7'd9;

  // protocol_mode codes
  localparam logic MODE_BINARY = 1'b0;
  localparam logic MODE_TEXT   = 1'b1;

  // frame_status codes
  localparam logic [1:0] FS_TEXT     = 2'd0;
  localparam logic [1:0] FS_GOOD     = 2'd1;
  localparam logic [1:0] FS_BAD_SUM  = 2'd2;
  localparam logic [1:0] FS_TOO_LONG = 2'd3;

  // readback sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } seq_state_t;

  // outcome of one binary-mode byte
  typedef struct packed {
    logic [BIN_ADDR_W-1:0]  wr_addr;
    logic                   emit_frame;
    logic                   emit_status;
    logic [1:0]             status;
    logic [FRAME_LEN_W-1:0] length;
  } bin_dec_t;

endpackage

// File: design/dmsfr_bin_track.sv
// Binary frame tracker: preamble hunt, length decode and checksum check.
// Keeps index, running sum, expected size and the header bytes it needs.
// Depends on dmsfr_pkg.
module dmsfr_bin_track import dmsfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  output bin_dec_t          dec
);

  logic [BIN_IDX_W-1:0]   idx, idx_next;
  logic [SUM_W-1:0]       sum, sum_next;
  logic [FRAME_LEN_W-1:0] exp_size, exp_size_next;
  logic [BYTE_W-1:0]      first, first_next;
  logic [BYTE_W-1:0]      prev;

  logic [BIN_IDX_W-1:0] idx_cur;
  logic [BIN_IDX_W-1:0] idx_inc;
  logic [SUM_W-1:0]     sum_add;
  logic [SIZE_W-1:0]    size;
  logic                 mismatch;

  always_comb begin
    idx_cur  = (idx >= BIN_IDX_W'(BIN_FRAME_MAX)) ? '0 : idx;
    idx_inc  = idx_cur + 1'b1;
    sum_add  = sum + {8'd0, rx_byte};
    size     = {1'b0, rx_byte, prev} + SIZE_EXTRA;
    mismatch = (first != PRE0) || (rx_byte != PRE1);

    idx_next         = idx_inc;
    sum_next         = sum_add;
    exp_size_next    = exp_size;
    first_next       = (idx_cur == '0) ? rx_byte : first;
    dec.wr_addr      = idx_cur[BIN_ADDR_W-1:0];
    dec.emit_frame   = 1'b0;
    dec.emit_status  = 1'b0;
    dec.status       = FS_GOOD;
    dec.length       = idx_inc;

    if (idx_inc == IDX_PREAMBLE_DONE) begin
      if (mismatch) begin
        // second byte slides down to become the first
        dec.wr_addr = '0;
        first_next  = rx_byte;
        idx_next    = BIN_IDX_W'(1);
      end else begin
        sum_next = {8'd0, PRE0} + {8'd0, PRE1};
      end
    end else if (idx_inc == IDX_LENGTH_DONE) begin
      if (size > SIZE_W'(BIN_FRAME_MAX)) begin
        dec.emit_status = 1'b1;
        dec.status      = FS_TOO_LONG;
        dec.length      = '0;
        idx_next        = '0;
        sum_next        = '0;
        exp_size_next   = '0;
      end else begin
        exp_size_next = size[FRAME_LEN_W-1:0];
      end
    end else if (idx_inc > IDX_MIN_END && idx_inc == exp_size) begin
      // sum before the two checksum bytes against the received checksum
      if ((sum - {8'd0, prev}) == {rx_byte, prev}) begin
        dec.emit_frame = 1'b1;
      end else begin
        dec.emit_status = 1'b1;
        dec.status      = FS_BAD_SUM;
      end
      idx_next = '0;
      sum_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      sum      <= '0;
      exp_size <= '0;
    end else if (step) begin
      idx      <= idx_next;
      sum      <= sum_next;
      exp_size <= exp_size_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      first <= first_next;
      prev  <= rx_byte;
    end
  end

endmodule

// File: design/dual_mode_serial_frame_receiver_top.sv
// A status-only result is in the output register in the cycle after its closing byte is taken.
// A frame run starts after its closing byte, then each byte goes through ST_READ (memory read)
// and ST_EMIT (output load), and ST_EMIT waits while the result side stalls.
// Input takes one byte per cycle outside runs while no result is held; a run holds off input.
// Reset (rst, synchronous): mode to binary, text pointer, binary index, sum and size cleared.
// Buffers are not cleared: only entries written since reset are ever read back.
// Depends on dmsfr_pkg and dmsfr_bin_track.
module dual_mode_serial_frame_receiver_top import dmsfr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [0:0]             cfg_data,
  // receive request channel
  input  logic                   rx_valid,
  output logic                   rx_stall,
  input  logic [BYTE_W-1:0]      rx_byte,
  // result request channel
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic [BYTE_W-1:0]      data_byte,
  output logic                   byte_valid,
  output logic [1:0]             frame_status,
  output logic [FRAME_LEN_W-1:0] frame_length,
  output logic                   last_of_run
);

  // mode register; writes must land only while idle, which the user keeps to, so no guard is kept
  logic protocol_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_mode <= MODE_BINARY;
    end else if (cfg_valid && cfg_ready) begin
      protocol_mode <= cfg_data[0];
    end
  end

  // handshake
  seq_state_t state, state_next;
  logic       out_free;
  logic       rx_take;
  logic       text_step;
  logic       bin_step;
  logic       em_load;

  assign out_free  = !res_valid || !res_stall;
  assign rx_take   = rx_valid && !rx_stall;
  assign text_step = rx_take && (protocol_mode == MODE_TEXT);
  assign bin_step  = rx_take && (protocol_mode == MODE_BINARY);

  // text path: pointer wraps at the buffer depth
  logic [TEXT_PTR_W-1:0] text_ptr;
  logic [TEXT_PTR_W-1:0] text_wr_ptr;
  logic [TEXT_PTR_W-1:0] text_ptr_next;
  logic                  text_close;

  always_comb begin
    text_wr_ptr   = (rx_byte == OPEN_MARK) ? '0 : text_ptr;
    text_ptr_next = (text_wr_ptr == TEXT_PTR_W'(TEXT_BUF_DEPTH - 1)) ? '0 : text_wr_ptr + 1'b1;
    text_close    = (rx_byte == CLOSE_MARK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_ptr <= '0;
    end else if (text_step) begin
      text_ptr <= text_ptr_next;
    end
  end

  // binary path
  bin_dec_t bin_dec;

  dmsfr_bin_track u_bin_track (
    .clk     (clk),
    .rst     (rst),
    .step    (bin_step),
    .rx_byte (rx_byte),
    .dec     (bin_dec)
  );

  // what this byte triggers
  logic                   start_run;
  logic                   start_status;
  logic [1:0]             trig_status;
  logic [FRAME_LEN_W-1:0] trig_len;

  always_comb begin
    start_run    = 1'b0;
    start_status = 1'b0;
    trig_status  = FS_TEXT;
    trig_len     = '0;
    if (text_step && text_close) begin
      if (text_ptr_next == '0) begin
        start_status = 1'b1;
      end else begin
        start_run = 1'b1;
        trig_len  = FRAME_LEN_W'(text_ptr_next);
      end
    end else if (bin_step) begin
      start_run    = bin_dec.emit_frame;
      start_status = bin_dec.emit_status;
      trig_status  = bin_dec.status;
      trig_len     = bin_dec.length;
    end
  end

  // frame buffers, each with a registered read
  logic [BYTE_W-1:0] text_mem [TEXT_BUF_DEPTH];
  logic [BYTE_W-1:0] bin_mem  [BIN_FRAME_MAX];
  logic [BYTE_W-1:0] text_rd_data;
  logic [BYTE_W-1:0] bin_rd_data;

  // readback sequencer registers
  logic [FRAME_LEN_W-1:0] rd_count;
  logic [FRAME_LEN_W-1:0] em_len;
  logic [1:0]             em_status;
  logic                   em_last;

  always_ff @(posedge clk) begin
    if (text_step) begin
      text_mem[text_wr_ptr] <= rx_byte;
    end
    text_rd_data <= text_mem[rd_count[TEXT_PTR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (bin_step) begin
      bin_mem[bin_dec.wr_addr] <= rx_byte;
    end
    bin_rd_data <= bin_mem[rd_count[BIN_ADDR_W-1:0]];
  end

  assign em_last = (rd_count + 1'b1) == em_len;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_run) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = em_last ? ST_IDLE : ST_READ;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs; input waits during a run and while a result is held
  always_comb begin
    rx_stall = 1'b1;
    em_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        rx_stall = !out_free;
      end
      ST_EMIT: begin
        em_load = out_free;
      end
      default: begin
        rx_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_count <= '0;
    end else begin
      state <= state_next;
      if (start_run) begin
        rd_count <= '0;
      end else if (em_load) begin
        rd_count <= rd_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_run) begin
      em_len    <= trig_len;
      em_status <= trig_status;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (start_status || em_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_status) begin
      data_byte    <= '0;
      byte_valid   <= 1'b0;
      frame_status <= trig_status;
      frame_length <= trig_len;
      last_of_run  <= 1'b1;
    end else if (em_load) begin
      data_byte    <= (em_status == FS_TEXT) ? text_rd_data : bin_rd_data;
      byte_valid   <= 1'b1;
      frame_status <= em_status;
      frame_length <= em_len;
      last_of_run  <= em_last;
    end
  end

endmodule

// File: design/dmsfr_checker.sv
// Port-level checks for the serial frame receiver, bound to the top level.
// Depends on dmsfr_pkg and dual_mode_serial_frame_receiver_top.
module dmsfr_checker import dmsfr_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   rx_valid,
  input logic                   rx_stall,
  input logic                   res_valid,
  input logic                   res_stall,
  input logic [BYTE_W-1:0]      data_byte,
  input logic                   byte_valid,
  input logic [1:0]             frame_status,
  input logic [FRAME_LEN_W-1:0] frame_length,
  input logic                   last_of_run
);

  // a status-only result always closes its run
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !byte_valid) |-> last_of_run)
    else $error("status-only result without last_of_run");

  // frame bytes only come from text or good binary frames, with a length
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && byte_valid) |->
      ((frame_status == FS_TEXT || frame_status == FS_GOOD) && frame_length != '0))
    else $error("frame byte with bad status or zero length");

  // no new request is taken while a run is still being read out
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && byte_valid && !last_of_run) |-> !(rx_valid && !rx_stall))
    else $error("input accepted in the middle of a run");

  // too-long status carries no length
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && frame_status == FS_TOO_LONG) |-> (frame_length == '0 && !byte_valid))
    else $error("too-long status with length or data");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(data_byte) && $stable(last_of_run)))
    else $error("stalled result changed");

endmodule

bind dual_mode_serial_frame_receiver_top dmsfr_checker u_dmsfr_checker (
  .clk          (clk),
  .rst          (rst),
  .rx_valid     (rx_valid),
  .rx_stall     (rx_stall),
  .res_valid    (res_valid),
  .res_stall    (res_stall),
  .data_byte    (data_byte),
  .byte_valid   (byte_valid),
  .frame_status (frame_status),
  .frame_length (frame_length),
  .last_of_run  (last_of_run)
);

// File: bench/testbench.sv
// Self-checking bench for dual_mode_serial_frame_receiver_top: random and directed byte streams
// in both protocol modes, each result checked against an in-bench frame predictor.
// Depends on dmsfr_pkg and the receiver RTL only.
`timescale 1ns / 100ps

module testbench;
  import dmsfr_pkg::*;

  localparam int HALF_PERIOD_NS  = 2;
  localparam int RESET_CYCLES    = 9;
  // Busy time after the last result, e.g. a byte still being stored when a run ends.
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 400;
  // The limit allows about four times the worst correct run (every byte closing a 64-byte
  // run under the longest random stalls).
  localparam longint LIMIT_NS    = 64'd20_000_000;
  localparam int MAX_PRINTED     = 40;

  typedef struct packed {
    logic [BYTE_W-1:0]      data;
    logic                   valid;
    logic [1:0]             status;
    logic [FRAME_LEN_W-1:0] length;
    logic                   fin;
  } frame_result_t;

  // DUT-facing signals; the ones the bench drives are known from time zero
  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [0:0]             cfg_data   = 1'b0;
  logic                   rx_valid   = 1'b0;
  logic                   rx_stall;
  logic [BYTE_W-1:0]      rx_byte    = '0;
  logic                   res_valid;
  logic                   res_stall  = 1'b0;
  logic [BYTE_W-1:0]      data_byte;
  logic                   byte_valid;
  logic [1:0]             frame_status;
  logic [FRAME_LEN_W-1:0] frame_length;
  logic                   last_of_run;

  // Bytes waiting to be offered, and results the predictor says are owed.
  logic [BYTE_W-1:0] rx_bytes_pending[$];
  frame_result_t     frame_results_due[$];

  // Predictor copy of the receiver state; each mode keeps its own.
  logic                   rx_mode;
  logic [BYTE_W-1:0]      text_store[TEXT_BUF_DEPTH];
  logic [TEXT_PTR_W-1:0]  text_wr_ptr;
  logic [BYTE_W-1:0]      bin_store[BIN_FRAME_MAX];
  logic [BIN_IDX_W-1:0]   bin_pos;
  logic [SUM_W-1:0]       bin_sum;
  logic [FRAME_LEN_W-1:0] bin_size;

  // Knobs set by the stimulus process (always at a falling edge).
  bit sender_gaps_on     = 1'b0;
  bit receiver_stalls_on = 1'b0;
  bit hold_off_request   = 1'b0;

  int gap_left, stall_left, hold_left;
  int bytes_sent, results_checked, mismatches, mode_writes;
  int good_frames, bad_sum_frames, too_long_frames, text_runs, text_wraps;

  dual_mode_serial_frame_receiver_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .data_byte    (data_byte),
    .byte_valid   (byte_valid),
    .frame_status (frame_status),
    .frame_length (frame_length),
    .last_of_run  (last_of_run)
  );

  always #HALF_PERIOD_NS clk = ~clk;

  // Mostly short idles, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_checked, name, got, want));
  endtask

  task automatic owe_result(input logic [BYTE_W-1:0] data, input logic valid,
                            input logic [1:0] status, input logic [FRAME_LEN_W-1:0] length,
                            input logic fin);
    frame_result_t r;
    r.data   = data;
    r.valid  = valid;
    r.status = status;
    r.length = length;
    r.fin    = fin;
    frame_results_due.push_back(r);
  endtask

  // Frame predictor: one accepted byte in, owed results appended.
  task automatic track_rx_byte(input logic [BYTE_W-1:0] b);
    logic [TEXT_PTR_W-1:0] ptr;
    logic [BIN_IDX_W-1:0]  pos;
    logic [SIZE_W-1:0]     size;
    logic [SUM_W-1:0]      body_sum;
    logic [SUM_W-1:0]      carried;
    int                    i;
    if (rx_mode == MODE_TEXT) begin
      ptr = (b == OPEN_MARK) ? '0 : text_wr_ptr;
      text_store[ptr] = b;
      ptr = ptr + 1'b1;                       // wraps at the buffer depth
      text_wr_ptr = ptr;
      if (b == CLOSE_MARK) begin
        text_runs++;
        if (ptr == 0) begin
          // pointer wrapped onto the close mark: empty status-only run
          text_wraps++;
          owe_result('0, 1'b0, FS_TEXT, '0, 1'b1);
        end else begin
          for (i = 0; i < ptr; i++)
            owe_result(text_store[i], 1'b1, FS_TEXT, FRAME_LEN_W'(ptr), i + 1 == ptr);
        end
      end
    end else begin
      pos = (bin_pos >= BIN_FRAME_MAX) ? '0 : bin_pos;
      bin_store[pos[BIN_ADDR_W-1:0]] = b;
      pos = pos + 1'b1;
      bin_sum = bin_sum + b;
      if (pos == IDX_PREAMBLE_DONE) begin
        if (bin_store[0] != PRE0 || bin_store[1] != PRE1) begin
          // slide the hunt by one byte
          bin_store[0] = bin_store[1];
          pos = 7'd1;
        end else begin
          bin_sum = SUM_W'(PRE0) + SUM_W'(PRE1);
        end
      end else if (pos == IDX_LENGTH_DONE) begin
        // judged on the full 17-bit size, so 0xFFF6 and up stay too long
        size = {1'b0, bin_store[7], bin_store[6]} + SIZE_EXTRA;
        if (size > BIN_FRAME_MAX) begin
          too_long_frames++;
          owe_result('0, 1'b0, FS_TOO_LONG, '0, 1'b1);
          pos      = '0;
          bin_sum  = '0;
          bin_size = '0;
        end else begin
          bin_size = size[FRAME_LEN_W-1:0];
        end
      end else if (pos > IDX_MIN_END && pos == bin_size) begin
        carried  = {bin_store[pos - 1], bin_store[pos - 2]};
        body_sum = bin_sum - bin_store[pos - 2] - bin_store[pos - 1];
        if (body_sum == carried) begin
          good_frames++;
          for (i = 0; i < pos; i++)
            owe_result(bin_store[i], 1'b1, FS_GOOD, pos, i + 1 == pos);
        end else begin
          bad_sum_frames++;
          owe_result('0, 1'b0, FS_BAD_SUM, pos, 1'b1);
        end
        bin_sum = '0;
        pos     = '0;
      end
      bin_pos = pos;
    end
  endtask

  // Sender: offers queued bytes, holds a stalled request steady, idles at random.
  always @(posedge clk) begin : rx_driver
    logic              offer;
    logic [BYTE_W-1:0] payload;
    if (rst) begin
      rx_valid <= 1'b0;
      rx_byte  <= '0;
      gap_left = 0;
    end else begin
      offer   = rx_valid;
      payload = rx_byte;
      if (rx_valid && !rx_stall) begin
        track_rx_byte(rx_byte);
        bytes_sent++;
        offer = 1'b0;
        if (sender_gaps_on) gap_left = pick_gap();
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (rx_bytes_pending.size() > 0) begin
          offer   = 1'b1;
          payload = rx_bytes_pending.pop_front();
        end
      end
      rx_valid <= offer;
      rx_byte  <= payload;
    end
  end

  // Receiver: checks every accepted result, stalls at random or for a long hold-off.
  always @(posedge clk) begin : result_monitor
    frame_result_t want;
    logic          stall_next;
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (frame_results_due.size() == 0) begin
          report_mismatch($sformatf("result %0d with none owed: data %0h status %0d",
                                    results_checked, data_byte, frame_status));
        end else begin
          want = frame_results_due.pop_front();
          check_field("data_byte", data_byte, want.data);
          check_field("byte_valid", byte_valid, want.valid);
          check_field("frame_status", frame_status, want.status);
          check_field("frame_length", frame_length, want.length);
          check_field("last_of_run", last_of_run, want.fin);
        end
        results_checked++;
      end
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        if (stall_left == 0 && receiver_stalls_on) stall_left = pick_gap();
        stall_next = stall_left > 0;
        if (stall_left > 0) stall_left--;
      end
      res_stall <= stall_next;
    end
  end

  // Wait until every byte is taken and every owed result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (rx_bytes_pending.size() != 0 || rx_valid || frame_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mode write, only ever issued while the receiver is idle.
  task automatic write_mode(input logic mode);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    rx_mode = mode;
    mode_writes++;
    @(negedge clk);
  endtask

  // Binary frame with random header and payload; too-long sizes stop after the length.
  task automatic queue_bin_frame(input logic [15:0] len, input bit spoil_sum);
    logic [BYTE_W-1:0] frame[$];
    logic [SUM_W-1:0]  sum;
    frame.push_back(PRE0);
    frame.push_back(PRE1);
    repeat (4) frame.push_back(8'($urandom));
    frame.push_back(len[7:0]);
    frame.push_back(len[15:8]);
    if (SIZE_W'(len) + SIZE_EXTRA <= BIN_FRAME_MAX) begin
      repeat (len) frame.push_back(8'($urandom));
      sum = '0;
      foreach (frame[i]) sum = sum + frame[i];
      if (spoil_sum) sum = sum ^ (16'd1 << $urandom_range(0, 15));
      frame.push_back(sum[7:0]);
      frame.push_back(sum[15:8]);
    end
    foreach (frame[i]) rx_bytes_pending.push_back(frame[i]);
  endtask

  task automatic queue_random_binary(input int n_bytes);
    int start, roll;
    logic [15:0] len;
    start = rx_bytes_pending.size();
    while (rx_bytes_pending.size() - start < n_bytes) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        // mostly short frames, a few up to the full buffer
        case ($urandom_range(0, 3))
          0, 1:    len = 16'($urandom_range(0, 10));
          2:       len = 16'($urandom_range(11, 53));
          default: len = 16'(BIN_FRAME_MAX - 10);
        endcase
        queue_bin_frame(len, roll >= 68);
      end else if (roll < 88) begin
        case ($urandom_range(0, 3))
          0:       len = 16'(BIN_FRAME_MAX - 9);     // one past the buffer
          1:       len = 16'hFFF6;                   // size wraps to zero in 16 bits
          2:       len = 16'hFFFF;
          default: len = 16'($urandom_range(56, 65535));
        endcase
        queue_bin_frame(len, 1'b0);
      end else if (roll < 95) begin
        repeat ($urandom_range(1, 3)) rx_bytes_pending.push_back(8'($urandom));
      end else begin
        // broken frame: preamble and a few bytes, then cut short
        rx_bytes_pending.push_back(PRE0);
        rx_bytes_pending.push_back(PRE1);
        repeat ($urandom_range(1, 6)) rx_bytes_pending.push_back(8'($urandom));
      end
    end
  endtask

  task automatic queue_text_frame(input int n_chars);
    rx_bytes_pending.push_back(OPEN_MARK);
    repeat (n_chars) rx_bytes_pending.push_back(8'($urandom));
    rx_bytes_pending.push_back(CLOSE_MARK);
  endtask

  task automatic queue_random_text(input int n_bytes);
    int start, roll;
    start = rx_bytes_pending.size();
    while (rx_bytes_pending.size() - start < n_bytes) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        case ($urandom_range(0, 7))
          0, 1, 2, 3: queue_text_frame($urandom_range(0, 12));
          4, 5:       queue_text_frame($urandom_range(13, 29));
          6:          queue_text_frame(TEXT_BUF_DEPTH - 2);   // lands on the wrap
          default:    queue_text_frame($urandom_range(31, 40));
        endcase
      end else if (roll < 85) begin
        repeat ($urandom_range(1, 4)) rx_bytes_pending.push_back(8'($urandom));
      end else if (roll < 95) begin
        rx_bytes_pending.push_back(CLOSE_MARK);
      end else begin
        rx_bytes_pending.push_back(OPEN_MARK);
      end
    end
  endtask

  initial begin : stimulus
    // Stray preamble byte then a minimal good frame (hunt slides by one),
    // then a frame whose length field is all ones.
    logic [BYTE_W-1:0] bin_opening[19] = '{
      PRE0, PRE0, PRE1, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'h00, 8'h00, 8'hBA, 8'h02,
      PRE0, PRE1, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF
    };
    // Empty frame, then a close mark with no open mark before it.
    logic [BYTE_W-1:0] text_opening[3] = '{OPEN_MARK, CLOSE_MARK, CLOSE_MARK};

    rx_mode     = MODE_BINARY;
    text_wr_ptr = '0;
    bin_pos     = '0;
    bin_sum     = '0;
    bin_size    = '0;
    foreach (text_store[i]) text_store[i] = '0;
    foreach (bin_store[i]) bin_store[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Binary mode, idling on both sides.
    write_mode(MODE_BINARY);
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    foreach (bin_opening[i]) rx_bytes_pending.push_back(bin_opening[i]);
    queue_bin_frame(16'd3, 1'b1);
    queue_random_binary(70);

    // Result side holds off for a long stretch while good frames keep arriving,
    // so the receiver must back up and stall its receive requests.
    hold_off_request = 1'b1;
    repeat (3) queue_bin_frame(16'($urandom_range(10, 30)), 1'b0);
    wait_drained();

    // Text mode; part way through the sender waits until every run is back.
    write_mode(MODE_TEXT);
    foreach (text_opening[i]) rx_bytes_pending.push_back(text_opening[i]);
    queue_text_frame(TEXT_BUF_DEPTH - 2);
    queue_random_text(45);
    wait_drained();
    queue_random_text(45);
    wait_drained();

    // Back to binary with no idling at all: any half-built frame resumes.
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    write_mode(MODE_BINARY);
    queue_random_binary(55);
    wait_drained();

    // Short text tail, sender gaps only.
    write_mode(MODE_TEXT);
    sender_gaps_on = 1'b1;
    queue_random_text(30);
    wait_drained();

    $display("run covered %0d bytes in, %0d results out, %0d mode writes",
             bytes_sent, results_checked, mode_writes);
    $display("binary good/bad-sum/too-long %0d/%0d/%0d, text runs %0d (%0d wrapped empty)",
             good_frames, bad_sum_frames, too_long_frames, text_runs, text_wraps);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("timeout with %0d results still owed", frame_results_due.size());
    $display("simulation failed");
    $finish;
  end

endmodule
